>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TFWF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define TFWF_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/tfwf_pkg.sv
// ----------------------------------------------------------------------------
// Trend-following window filter package
// Types and fixed constants shared by the filter RTL.
// ----------------------------------------------------------------------------
package tfwf_pkg;

  localparam int SAMPLE_W = 12;

  // The mean is formed in tenths and rounded up when the tenths digit exceeds
  // this value.
  localparam int TENTHS      = 10;
  localparam int ROUND_DIGIT = 5;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUO,
    ST_REM,
    ST_CORR,
    ST_SCAN,
    ST_DONE
  } tfwf_state_t;

endpackage

>>> rtl/core/trend_following_window_filter_top.sv
// ----------------------------------------------------------------------------
// Trend-following window filter
// Window mean with tenths rounding, followed by a trend-directed search of the
// window for the next output value (else the average of mean and last output).
// ----------------------------------------------------------------------------
// One item holds the block from its accept until its result is loaded. The
// accept takes the sample and updates the window and its running sum; four
// steps form the mean (reciprocal multiply, quotient, remainder, correction
// and rounding); a single compare unit then visits window positions 1 to
// WINDOW_LEN - 1 one per cycle; and the done state loads the output register
// once the result side is not stalled. in_stall is high from the accept
// until the result is loaded; a finished result may wait in the output
// register while the next sample is accepted.
module trend_following_window_filter_top
  import tfwf_pkg::*;
#(
  parameter int WINDOW_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_filtered
);

  localparam int SUM_W   = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);
  localparam int IDX_W   = $clog2(WINDOW_LEN);
  localparam int K       = SUM_W + $clog2(WINDOW_LEN);
  localparam int PROD_W  = SUM_W + K;
  localparam int REM_W   = $clog2(2 * WINDOW_LEN);
  localparam int RND_W   = $clog2(TENTHS * 2 * WINDOW_LEN);
  localparam int RND_LIM = (ROUND_DIGIT + 1) * WINDOW_LEN;
  localparam longint unsigned RECIP_L = (64'd1 << K) / WINDOW_LEN;
  localparam logic [K-1:0] RECIP = K'(RECIP_L);

  tfwf_state_t state_r, state_nxt;

  sample_t              window_r [WINDOW_LEN];
  logic [SUM_W-1:0]     sum_r;
  logic [PROD_W-1:0]    prod_r;
  sample_t              quot_r;
  logic [REM_W-1:0]     rem_r;
  sample_t              mean_r;
  sample_t              pick_r;
  logic                 found_r;
  logic [IDX_W-1:0]     idx_r;
  sample_t              last_r;
  logic                 out_valid_r;
  sample_t              out_filtered_r;

  logic                 in_acc;
  logic                 load_out;
  logic                 scan_last;
  logic [SUM_W-1:0]     rem_full;
  sample_t              quot_cor;
  logic [REM_W-1:0]     rem_cor;
  logic                 round_up;
  sample_t              mean_c;
  sample_t              cand;
  logic                 rising;
  logic                 hit;
  logic [SAMPLE_W:0]    avg_sum;
  sample_t              result;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_QUO;
      ST_QUO:  state_nxt = ST_REM;
      ST_REM:  state_nxt = ST_CORR;
      ST_CORR: state_nxt = ST_SCAN;
      ST_SCAN: if (scan_last) state_nxt = ST_DONE;
      ST_DONE: if (!(out_valid_r && out_stall)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_DONE: load_out = !(out_valid_r && out_stall);
      default: begin
        in_stall = 1'b1;
        load_out = 1'b0;
      end
    endcase
  end

  assign in_acc    = in_valid && !in_stall;
  assign scan_last = (idx_r == IDX_W'(WINDOW_LEN - 1));

  // Remainder, one-step correction of the reciprocal estimate and rounding.
  assign rem_full = sum_r - SUM_W'(SUM_W'(quot_r) * SUM_W'(WINDOW_LEN));
  assign quot_cor = (rem_r >= REM_W'(WINDOW_LEN)) ? quot_r + 1'b1 : quot_r;
  assign rem_cor  = (rem_r >= REM_W'(WINDOW_LEN)) ? rem_r - REM_W'(WINDOW_LEN) : rem_r;
  assign round_up = (RND_W'(rem_cor) * RND_W'(TENTHS)) >= RND_W'(RND_LIM);
  assign mean_c   = quot_cor + sample_t'(round_up);

  // Shared compare unit for the window search. An equal mean never hits,
  // and the fallback average then gives back the old output.
  assign cand   = window_r[idx_r];
  assign rising = mean_r > last_r;
  assign hit    = rising ? ((cand > last_r) && (cand < pick_r))
                         : ((cand < last_r) && (cand > pick_r));

  assign avg_sum = {1'b0, last_r} + {1'b0, mean_r};
  assign result  = found_r ? pick_r : avg_sum[SAMPLE_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      last_r      <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          window_r[i] <= window_r[i+1];
        end
        window_r[WINDOW_LEN-1] <= in_sample;
        sum_r <= sum_r + SUM_W'(in_sample) - SUM_W'(window_r[0]);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        last_r      <= result;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL: prod_r <= PROD_W'(sum_r) * PROD_W'(RECIP);
      ST_QUO: quot_r <= prod_r[K +: SAMPLE_W];
      ST_REM: rem_r  <= rem_full[REM_W-1:0];
      ST_CORR: begin
        mean_r  <= mean_c;
        pick_r  <= mean_c;
        found_r <= 1'b0;
        idx_r   <= IDX_W'(1);
      end
      ST_SCAN: begin
        if (hit) begin
          pick_r  <= cand;
          found_r <= 1'b1;
        end
        if (!scan_last) idx_r <= idx_r + 1'b1;
      end
      ST_DONE: if (load_out) out_filtered_r <= result;
      default: begin
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

`include "assert_macros.svh"

  `TFWF_ASSERT(a_accept_starts_mean, clk, rst_n, (in_valid && !in_stall) |=> (state_r == ST_MUL), "accepted item did not start the mean computation")
  `TFWF_ASSERT(a_rem_bounded, clk, rst_n, (state_r == ST_CORR) |-> (int'(rem_r) < 2 * WINDOW_LEN), "reciprocal estimate off by more than one")
  `TFWF_ASSERT(a_scan_skips_oldest, clk, rst_n, (state_r == ST_SCAN) |-> (idx_r != '0), "search visited the oldest window position")
  `TFWF_ASSERT(a_result_loaded, clk, rst_n, (state_r == ST_DONE && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == ST_IDLE), "finished item was not presented")

endmodule
